### rtl/arpc_pkg.sv
// shared types and constants of the arp responder with ip-to-mac cache
// no dependencies; imported by arpc_scan, the top level and arpc_checker
package arpc_pkg;

  localparam int CACHE_ENTRIES = 8;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int IP_W = 32;
  localparam int MAC_W = 48;
  localparam int ENTRY_W = IP_W + MAC_W;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC = 1'b1;

  localparam logic [10:0] MIN_ARP_BYTES = 11'd28;
  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [7:0] HW_ADDR_LEN = 8'd6;
  localparam logic [7:0] PROTO_ADDR_LEN = 8'd4;
  localparam logic [15:0] OPC_REQUEST = 16'h0001;
  localparam logic [15:0] OPC_REPLY = 16'h0002;
  localparam logic [IP_W-1:0] IP_BROADCAST = 32'hFFFF_FFFF;
  localparam logic [MAC_W-1:0] MAC_BROADCAST = 48'hFFFF_FFFF_FFFF;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    OUTC_DROPPED = 3'd0,
    OUTC_CACHED  = 3'd1,
    OUTC_REPLY   = 3'd2,
    OUTC_HIT     = 3'd3,
    OUTC_MISS    = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    SEND_NONE    = 2'd0,
    SEND_REQUEST = 2'd1,
    SEND_REPLY   = 2'd2
  } send_op_t;

  typedef struct packed {
    logic             kind;
    logic [10:0]      frame_length;
    logic [15:0]      hardware_type;
    logic [15:0]      protocol_type;
    logic [7:0]       hardware_length;
    logic [7:0]       protocol_length;
    logic [15:0]      operation;
    logic [MAC_W-1:0] sender_hw_address;
    logic [IP_W-1:0]  sender_proto_address;
    logic [IP_W-1:0]  target_proto_address;
    logic [IP_W-1:0]  query_address;
  } in_t;

  typedef struct packed {
    outcome_t         outcome;
    logic [MAC_W-1:0] resolved_mac;
    send_op_t         out_operation;
    logic [MAC_W-1:0] out_sender_hw;
    logic [IP_W-1:0]  out_sender_proto;
    logic [MAC_W-1:0] out_target_hw;
    logic [IP_W-1:0]  out_target_proto;
    logic [MAC_W-1:0] frame_destination;
  } out_t;

  // request from the top level to the cache scanner
  typedef struct packed {
    logic             go;
    logic             insert;
    logic [IP_W-1:0]  key_ip;
    logic [MAC_W-1:0] wr_mac;
  } scan_req_t;

  typedef struct packed {
    logic             done;
    logic             hit;
    logic [MAC_W-1:0] mac;
  } scan_res_t;

endpackage

### rtl/arpc_ram.sv
// generic single-write, single-read synchronous ram, registered read data
// no dependencies
module arpc_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 80,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/arpc_scan.sv
// cache scanner: walks the ip/mac ram one entry per read, finds a match or a
// free slot, then writes back the sender if req.insert is set; valid bits and
// victim pointer live here; depends on arpc_pkg and arpc_ram
module arpc_scan
  import arpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  scan_req_t req,
  output scan_res_t res,
  output logic      busy
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_CMP  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

  state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic free_ok_r, free_ok_nxt;
  logic [IDX_W-1:0] free_idx_r, free_idx_nxt;
  logic [MAC_W-1:0] mac_r, mac_nxt;
  logic [CACHE_ENTRIES-1:0] valid_r;
  logic [IDX_W-1:0] victim_r;

  logic [ENTRY_W-1:0] rd_data;
  logic [IP_W-1:0] entry_ip;
  logic [MAC_W-1:0] entry_mac;
  logic cmp_hit;
  logic wr_en;
  logic [IDX_W-1:0] slot;

  assign entry_ip = rd_data[ENTRY_W-1:MAC_W];
  assign entry_mac = rd_data[MAC_W-1:0];
  assign cmp_hit = valid_r[idx_r] && (entry_ip == req.key_ip);

  // update in place, else lowest free slot, else round-robin victim
  assign slot = hit_r ? hit_idx_r : (free_ok_r ? free_idx_r : victim_r);
  assign wr_en = (state_r == S_FIN) && req.insert;

  arpc_ram #(
    .DEPTH (CACHE_ENTRIES),
    .WIDTH (ENTRY_W),
    .AW    (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (slot),
    .wdata ({req.key_ip, req.wr_mac}),
    .re    (state_r == S_READ),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  always_comb begin
    state_nxt = state_r;
    idx_nxt = idx_r;
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    free_ok_nxt = free_ok_r;
    free_idx_nxt = free_idx_r;
    mac_nxt = mac_r;
    case (state_r)
      S_IDLE: begin
        if (req.go) begin
          idx_nxt = '0;
          hit_nxt = 1'b0;
          free_ok_nxt = 1'b0;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (cmp_hit) begin
          hit_nxt = 1'b1;
          hit_idx_nxt = idx_r;
          mac_nxt = entry_mac;
          state_nxt = S_FIN;
        end else begin
          if (!valid_r[idx_r] && !free_ok_r) begin
            free_ok_nxt = 1'b1;
            free_idx_nxt = idx_r;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FIN;
          end else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_FIN: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      victim_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (wr_en) begin
        valid_r[slot] <= 1'b1;
        if (!hit_r && !free_ok_r) begin
          victim_r <= (victim_r == LAST_IDX) ? '0 : victim_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    hit_r <= hit_nxt;
    hit_idx_r <= hit_idx_nxt;
    free_ok_r <= free_ok_nxt;
    free_idx_r <= free_idx_nxt;
    mac_r <= mac_nxt;
  end

  assign res.done = (state_r == S_FIN);
  assign res.hit = hit_r;
  assign res.mac = mac_r;
  assign busy = (state_r != S_IDLE);

endmodule

### rtl/arp_responder_with_cache.sv
// top level of the arp responder: local address registers, request checks,
// result formatting; depends on arpc_pkg and arpc_scan
//
//  channel | ports                          | handshake
//  --------+--------------------------------+------------------------------------
//  input   | start, busy, in_item           | taken when start high and busy low
//  result  | out_valid, out_item            | one-cycle strobe, always taken
//  config  | cfg_we, cfg_index, cfg_wdata   | written on any edge with cfg_we high
//
// a dropped packet or a broadcast query gives its result through fast_r and
// out_valid_r; anything else scans the cache ram, reading and then comparing
// each entry in turn, and stops at the first match or after the last entry.
// one request is in flight at a time; busy stays high until the result strobe.
// reset clears the valid bits, victim pointer and local addresses at once.
// the receiver cannot stall: every result is shown for exactly one cycle.
module arp_responder_with_cache
  import arpc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_t                  in_item,
  output logic                 out_valid,
  output out_t                 out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  function automatic logic pkt_ok(input in_t it);
    return (it.frame_length >= MIN_ARP_BYTES) && (it.hardware_type == HW_ETHERNET) &&
           (it.protocol_type == PROTO_IPV4) && (it.hardware_length == HW_ADDR_LEN) &&
           (it.protocol_length == PROTO_ADDR_LEN);
  endfunction

  logic [IP_W-1:0] local_ip_r;
  logic [MAC_W-1:0] local_mac_r;
  in_t item_r;
  logic fast_r;
  logic out_valid_r;
  out_t out_r;
  out_t fmt;

  logic accept;
  logic need_scan;
  logic scan_busy;
  scan_req_t req;
  scan_res_t res;

  assign accept = start && !busy;
  assign need_scan = (in_item.kind == KIND_QUERY) ? (in_item.query_address != IP_BROADCAST)
                                                  : pkt_ok(in_item);

  assign req.go = accept && need_scan;
  assign req.insert = (item_r.kind == KIND_PACKET);
  assign req.key_ip = (item_r.kind == KIND_QUERY) ? item_r.query_address
                                                  : item_r.sender_proto_address;
  assign req.wr_mac = item_r.sender_hw_address;

  arpc_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .res   (res),
    .busy  (scan_busy)
  );

  assign busy = fast_r || scan_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r <= '0;
      local_mac_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LOCAL_IP:  local_ip_r <= cfg_wdata[IP_W-1:0];
        CFG_LOCAL_MAC: local_mac_r <= cfg_wdata[MAC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  always_comb begin
    fmt = '0;
    if (item_r.kind == KIND_QUERY) begin
      if (item_r.query_address == IP_BROADCAST) begin
        fmt.outcome = OUTC_HIT;
        fmt.resolved_mac = MAC_BROADCAST;
      end else if (res.hit) begin
        fmt.outcome = OUTC_HIT;
        fmt.resolved_mac = res.mac;
      end else begin
        fmt.outcome = OUTC_MISS;
        fmt.out_operation = SEND_REQUEST;
        fmt.out_sender_hw = local_mac_r;
        fmt.out_sender_proto = local_ip_r;
        fmt.out_target_proto = item_r.query_address;
        fmt.frame_destination = MAC_BROADCAST;
      end
    end else if (pkt_ok(item_r)) begin
      fmt.outcome = OUTC_CACHED;
      if ((item_r.operation == OPC_REQUEST) &&
          (item_r.target_proto_address == local_ip_r)) begin
        fmt.outcome = OUTC_REPLY;
        fmt.out_operation = SEND_REPLY;
        fmt.out_sender_hw = local_mac_r;
        fmt.out_sender_proto = local_ip_r;
        fmt.out_target_hw = item_r.sender_hw_address;
        fmt.out_target_proto = item_r.sender_proto_address;
        fmt.frame_destination = item_r.sender_hw_address;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fast_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fast_r <= accept && !need_scan;
      out_valid_r <= fast_r || res.done;
    end
  end

  always_ff @(posedge clk) begin
    if (fast_r || res.done) begin
      out_r <= fmt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item = out_r;

endmodule

### rtl/arpc_checker.sv
// port-level checks on the arp responder, attached by bind below
// depends on arpc_pkg and the top level arp_responder_with_cache
module arpc_checker
  import arpc_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  start,
  input logic                  busy,
  input in_t                   in_item,
  input logic                  out_valid,
  input out_t                  out_item,
  input logic                  cfg_we,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  // a taken request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after a request was taken");

  // no result can appear in the cycle right after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobe one cycle after request");

  // one result per request: strobes never come back to back
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a result is only shown once the block has finished the request
  a_idle_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

  // nothing to send unless the outcome is a reply or a miss
  a_send_matches_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.out_operation != SEND_NONE)) |->
      (out_item.outcome == OUTC_REPLY || out_item.outcome == OUTC_MISS))
    else $error("send opcode without reply or miss outcome");

endmodule

bind arp_responder_with_cache arpc_checker u_arpc_checker (.*);
